// ===== hw/rtl/bdcs_pkg.sv =====
// Shared types and constants for the button debounce and channel select block.
package bdcs_pkg;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned SRC_W       = 3;
  localparam int unsigned MAX_LANES   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Buttons with a special meaning.
  localparam int unsigned HOME_BUTTON = 3;
  localparam int unsigned UP_BUTTON   = 4;
  localparam int unsigned DOWN_BUTTON = 5;

  // Reset values of the configuration registers.
  localparam logic [DELAY_W-1:0] SETTLE_MS_RST     = 16'd50;
  localparam logic [CODE_W-1:0]  BASE_CHAN_RST     = 8'd0;
  localparam logic [CODE_W-1:0]  CHANNEL_COUNT_RST = 8'd16;

  typedef enum logic [1:0] {
    CFG_SETTLE_MS     = 2'd0,
    CFG_BASE_CHAN     = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DELAY_W-1:0] settle_ms;
    logic [CODE_W-1:0]  base_chan;
    logic [CODE_W-1:0]  channel_count;
  } cfg_t;

endpackage

// ===== hw/rtl/bdcs_in_if.sv =====
// Input channel carrying one sample of all button levels and its timestamp.
interface bdcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdcs_pkg::LEVEL_W-1:0]   levels;
  logic [bdcs_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, output levels, output now_ms, input ready);
  modport sink   (input valid, input levels, input now_ms, output ready);
endinterface

// ===== hw/rtl/bdcs_out_if.sv =====
// Output channel carrying one press event with its transmit code.
interface bdcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [bdcs_pkg::CODE_W-1:0]  ir_code;
  logic [bdcs_pkg::SRC_W-1:0]   source_button;
  logic                         last;

  modport source (output valid, output ir_code, output source_button, output last,
                  input ready);
  modport sink   (input valid, input ir_code, input source_button, input last,
                  output ready);
endinterface

// ===== hw/rtl/button_debounce_channel_select.sv =====
// Top level of the multi-button debounce with press events and channel stepping.
//
//   Port       Direction  Carries
//   in_i       sink       levels[7:0], now_ms[31:0]: one sample of every button
//   out_o      source     ir_code[7:0], source_button[2:0], last: one press event
//   cfg_*_i    write      settle time, base channel, channel count
//
// The front end takes a sample whenever the press queue has room, and a
// sample without any press leaves nothing behind it. The back end first loads
// a press mask and then handles its pressed buttons one by one in button
// order. An output register holds each result; a stalled output stops the
// scan but not the front end until the queue fills. Reset clears all debounce
// state and the channel.
module button_debounce_channel_select #(
  parameter int unsigned BUTTON_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [bdcs_pkg::DELAY_W-1:0]   cfg_data_i,
  bdcs_in_if.sink                        in_i,
  bdcs_out_if.source                     out_o
);
  import bdcs_pkg::*;

  // Only eight levels arrive with a sample, so buttons above seven always
  // read low and never produce an event; they keep no state.
  localparam int unsigned LANES = (BUTTON_COUNT < MAX_LANES) ? BUTTON_COUNT : MAX_LANES;

  cfg_t             cfg_q;
  logic             q_push, q_full, q_pop, q_empty;
  logic [LANES-1:0] q_wdata, q_rdata;

  // Configuration registers. Writing the home channel does not move the
  // current channel; the back end reads these values as it scans.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms     <= SETTLE_MS_RST;
      cfg_q.base_chan     <= BASE_CHAN_RST;
      cfg_q.channel_count <= CHANNEL_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETTLE_MS:     cfg_q.settle_ms     <= cfg_data_i;
        CFG_BASE_CHAN:     cfg_q.base_chan     <= cfg_data_i[CODE_W-1:0];
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Debounce every button on each transfer and collect the rising edges.
  bdcs_front #(
    .LANES (LANES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_mask_o (q_wdata)
  );

  // Press masks wait here so that either side can stall on its own.
  bdcs_queue #(
    .WIDTH (LANES)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Walk each mask in button order, stepping the channel where needed.
  bdcs_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_mask_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ===== hw/rtl/bdcs_front.sv =====
// Front end: per-button debounce on each accepted sample, producing a press mask.
module bdcs_front #(
  parameter int unsigned LANES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdcs_pkg::cfg_t        cfg_i,
  bdcs_in_if.sink               in_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [LANES-1:0]      q_mask_o
);
  import bdcs_pkg::*;

  logic [LANES-1:0]  prev_q, prev_d;
  logic [LANES-1:0]  stable_q, stable_d;
  logic [TIME_W-1:0] ctime_q [LANES];
  logic [TIME_W-1:0] ctime_d [LANES];
  logic [LANES-1:0]  press;
  logic              accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // Each lane is independent: one subtract and compare per button.
  always_comb begin
    logic              r;
    logic [TIME_W-1:0] elapsed;
    prev_d   = prev_q;
    stable_d = stable_q;
    press    = '0;
    for (int i = 0; i < LANES; i++) begin
      ctime_d[i] = ctime_q[i];
      r          = in_i.levels[i];
      elapsed    = in_i.now_ms - ctime_q[i];
      if (accept) begin
        prev_d[i] = r;
        if (r != prev_q[i]) begin
          ctime_d[i] = in_i.now_ms;
        end else if ((elapsed > TIME_W'(cfg_i.settle_ms)) && (r != stable_q[i])) begin
          stable_d[i] = r;
          press[i]    = r;
        end
      end
    end
  end

  assign q_push_o = accept && (press != '0);
  assign q_mask_o = press;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      for (int i = 0; i < LANES; i++) begin
        ctime_q[i] <= '0;
      end
    end else begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      for (int i = 0; i < LANES; i++) begin
        ctime_q[i] <= ctime_d[i];
      end
    end
  end

endmodule

// ===== hw/rtl/bdcs_queue.sv =====
// Short queue of press masks between the front end and the back end.
module bdcs_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import bdcs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/bdcs_back.sv =====
// Back end: scans a press mask in button order and issues one code per cycle while the output is not stalled.
module bdcs_back #(
  parameter int unsigned LANES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdcs_pkg::cfg_t   cfg_i,
  input  logic             q_empty_i,
  input  logic [LANES-1:0] q_mask_i,
  output logic             q_pop_o,
  bdcs_out_if.source       out_o
);
  import bdcs_pkg::*;

  localparam int unsigned IDX_W = $clog2(LANES);

  logic [LANES-1:0]  mask_q, mask_d, rest;
  logic [IDX_W-1:0]  sel;
  logic [CODE_W-1:0] chan_q, chan_d, code;
  logic [CODE_W:0]   chan_up;
  logic              adv;
  logic              ov_q, ov_d;
  logic [CODE_W-1:0] code_q;
  logic [SRC_W-1:0]  src_q;
  logic              last_q;

  // Lowest pending button goes first.
  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign rest    = mask_q & (mask_q - 1'b1);
  assign adv     = (mask_q != '0) && (!ov_q || out_o.ready);
  assign q_pop_o = (mask_q == '0) && !q_empty_i;
  assign chan_up = {1'b0, chan_q} + 1'b1;

  always_comb begin
    chan_d = chan_q;
    code   = CODE_W'(sel);
    case (sel)
      IDX_W'(HOME_BUTTON): begin
        code = cfg_i.base_chan;
      end
      IDX_W'(UP_BUTTON): begin
        if (chan_up >= {1'b0, cfg_i.channel_count}) begin
          code = cfg_i.base_chan;
        end else begin
          code = chan_up[CODE_W-1:0];
        end
        chan_d = code;
      end
      IDX_W'(DOWN_BUTTON): begin
        if (chan_q <= cfg_i.base_chan) begin
          code = cfg_i.channel_count - 1'b1;
        end else begin
          code = chan_q - 1'b1;
        end
        chan_d = code;
      end
      default: begin
        code = CODE_W'(sel);
      end
    endcase
  end

  always_comb begin
    mask_d = mask_q;
    if (q_pop_o) begin
      mask_d = q_mask_i;
    end else if (adv) begin
      mask_d = rest;
    end
    ov_d = ov_q;
    if (adv) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      chan_q <= BASE_CHAN_RST;
      ov_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      ov_q   <= ov_d;
      if (adv) begin
        chan_q <= chan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code_q <= code;
      src_q  <= SRC_W'(sel);
      last_q <= (rest == '0);
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.ir_code       = code_q;
  assign out_o.source_button = src_q;
  assign out_o.last          = last_q;

endmodule
